### src/smb_pkg.sv
// Shared types and codes of the dual-stack core: request and response payloads,
// controller-to-datapath command and status groups, opcode and fault codes.
// No dependencies.
package smb_pkg;

    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_PUSH  = 3'd2;
    localparam logic [2:0] ACT_POP   = 3'd3;
    localparam logic [2:0] ACT_START = 3'd4;
    localparam logic [2:0] ACT_STEP  = 3'd5;

    localparam logic [2:0] FLT_NONE   = 3'd0;
    localparam logic [2:0] FLT_OPCODE = 3'd1;
    localparam logic [2:0] FLT_DATA   = 3'd2;
    localparam logic [2:0] FLT_RET    = 3'd3;
    localparam logic [2:0] FLT_DIV    = 3'd4;
    localparam logic [2:0] FLT_ADDR   = 3'd5;
    localparam logic [2:0] FLT_DEVICE = 3'd6;

    localparam logic [1:0] IO_NONE   = 2'd0;
    localparam logic [1:0] IO_QUERY  = 2'd1;
    localparam logic [1:0] IO_INVOKE = 2'd2;

    localparam logic [7:0] OP_NOP    = 8'd0;
    localparam logic [7:0] OP_LIT    = 8'd1;
    localparam logic [7:0] OP_DUP    = 8'd2;
    localparam logic [7:0] OP_DROP   = 8'd3;
    localparam logic [7:0] OP_SWAP   = 8'd4;
    localparam logic [7:0] OP_TOR    = 8'd5;
    localparam logic [7:0] OP_FROMR  = 8'd6;
    localparam logic [7:0] OP_JUMP   = 8'd7;
    localparam logic [7:0] OP_CALL   = 8'd8;
    localparam logic [7:0] OP_CCALL  = 8'd9;
    localparam logic [7:0] OP_RET    = 8'd10;
    localparam logic [7:0] OP_EQ     = 8'd11;
    localparam logic [7:0] OP_NE     = 8'd12;
    localparam logic [7:0] OP_LT     = 8'd13;
    localparam logic [7:0] OP_GT     = 8'd14;
    localparam logic [7:0] OP_FETCH  = 8'd15;
    localparam logic [7:0] OP_STORE  = 8'd16;
    localparam logic [7:0] OP_ADD    = 8'd17;
    localparam logic [7:0] OP_SUB    = 8'd18;
    localparam logic [7:0] OP_MUL    = 8'd19;
    localparam logic [7:0] OP_DIVMOD = 8'd20;
    localparam logic [7:0] OP_AND    = 8'd21;
    localparam logic [7:0] OP_OR     = 8'd22;
    localparam logic [7:0] OP_XOR    = 8'd23;
    localparam logic [7:0] OP_SHIFT  = 8'd24;
    localparam logic [7:0] OP_ZRET   = 8'd25;
    localparam logic [7:0] OP_HALT   = 8'd26;
    localparam logic [7:0] OP_DEVCNT = 8'd27;
    localparam logic [7:0] OP_QUERY  = 8'd28;
    localparam logic [7:0] OP_INVOKE = 8'd29;
    localparam logic [7:0] OP_LAST   = OP_INVOKE;

    typedef struct packed {
        logic [2:0]         action;
        logic [15:0]        address;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [16:0]        instr_address;
        logic               halted;
        logic [2:0]         fault;
        logic [1:0]         io_request;
        logic [2:0]         io_device;
        logic [10:0]        data_depth;
    } t_rsp;

    typedef enum logic [1:0] {DSA_DP, DSA_DP1, DSA_DP2} t_ds_addr;
    typedef enum logic [3:0] {
        WD_HOST, WD_MEM, WD_DEVCNT, WD_R, WD_T, WD_N, WD_SPECIAL, WD_ALU, WD_QUO, WD_REM
    } t_ds_wd;
    typedef enum logic [1:0] {PTR_HOLD, PTR_INC, PTR_DEC, PTR_DEC2} t_ptr_op;
    typedef enum logic [2:0] {CUR_HOLD, CUR_IP, CUR_INC, CUR_T_M1, CUR_R} t_cur_op;
    typedef enum logic [1:0] {IP_HOLD, IP_HOST, IP_CUR, IP_CUR_P1} t_ip_op;
    typedef enum logic [1:0] {MRA_HOST, MRA_IP, MRA_CUR_P1, MRA_T} t_mem_ra;
    typedef enum logic [1:0] {RES_HOLD, RES_ZERO, RES_MEM, RES_DS} t_res_op;

    typedef struct packed {
        logic     ld_req;
        logic     ds_we;
        t_ds_addr ds_wa;
        t_ds_wd   ds_wd;
        t_ds_addr ds_ra;
        t_ptr_op  dp_op;
        logic     rs_we;
        logic     rs_wd_cur;
        t_ptr_op  rp_op;
        t_cur_op  cur_op;
        t_ip_op   ip_op;
        logic     mem_we;
        logic     mem_wa_host;
        t_mem_ra  mem_ra;
        logic     ld_t;
        logic     ld_n;
        logic     ld_r;
        logic     ld_word;
        logic     ld_alu;
        logic     ld_dev;
        logic     div_start;
        t_res_op  res_op;
        logic [1:0] slot;
    } t_dp_cmd;

    typedef struct packed {
        logic [7:0] op;
        logic       dp_lt1;
        logic       dp_lt2;
        logic       dp_full;
        logic       rp_zero;
        logic       rp_full;
        logic       t_zero;
        logic       n_zero;
        logic       t_mem_ok;
        logic       t_dev_ok;
        logic       t_special;
        logic       cur_p1_ge;
        logic       cur_p1_neg;
        logic       ip_ge;
        logic       ip_neg;
        logic       host_ok;
        logic       word_bad;
        logic       div_done;
    } t_dp_status;

endpackage

### src/stack_machine_bundle_core.sv
// Dual-stack core with 32-bit cells; one request in flight, one response per request.
// Host write, read, push, pop and start each end with the o_valid strobe.
// A step fetches and checks the word, then runs each opcode slot through three registered
// stack reads, execute and advance; a divmod slot also waits for the bit-serial divider.
// Reset zeroes the pointers and clears halt, fault and any paused word; the memories
// keep their contents and get no clearing pass. The receiver cannot stall the strobe.
module stack_machine_bundle_core #(
    parameter int MEM_DEPTH    = 65536,
    parameter int DATA_DEPTH   = 1024,
    parameter int RET_DEPTH    = 1024,
    parameter int DEVICE_COUNT = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  smb_pkg::t_req i_req,
    output logic          o_valid,
    output smb_pkg::t_rsp o_rsp
);
    smb_pkg::t_dp_cmd    cmd;
    smb_pkg::t_dp_status status;
    logic [31:0] res_value;
    logic [16:0] ip;
    logic [10:0] depth;
    logic [2:0]  dev;
    logic        halted;
    logic [2:0]  fault;
    logic [1:0]  io_kind;

    smb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_status  (status),
        .o_busy    (busy),
        .o_cmd     (cmd),
        .o_valid   (o_valid),
        .o_halted  (halted),
        .o_fault   (fault),
        .o_io_kind (io_kind)
    );

    smb_datapath #(
        .MEM_DEPTH    (MEM_DEPTH),
        .DATA_DEPTH   (DATA_DEPTH),
        .RET_DEPTH    (RET_DEPTH),
        .DEVICE_COUNT (DEVICE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_res_value (res_value),
        .o_ip        (ip),
        .o_depth     (depth),
        .o_dev       (dev)
    );

    // A halted core reports the memory depth as its instruction address.
    always_comb begin
        o_rsp.result_value  = res_value;
        o_rsp.instr_address = halted ? 17'(MEM_DEPTH) : ip;
        o_rsp.halted        = halted;
        o_rsp.fault         = fault;
        o_rsp.io_request    = io_kind;
        o_rsp.io_device     = (io_kind != smb_pkg::IO_NONE) ? dev : 3'd0;
        o_rsp.data_depth    = depth;
    end
endmodule

### src/smb_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its ports.
module smb_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_acc;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic        r_negq;
    logic        r_negr;
    logic [32:0] shifted;
    logic [32:0] trial;

    assign shifted = {r_rem, r_acc[31]};
    assign trial   = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_dvs  <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_rem  <= '0;
            r_negq <= i_dividend[31] ^ i_divisor[31];
            r_negr <= i_dividend[31];
        end else if (r_busy) begin
            if (!trial[32]) begin
                r_rem <= trial[31:0];
                r_acc <= {r_acc[30:0], 1'b1};
            end else begin
                r_rem <= shifted[31:0];
                r_acc <= {r_acc[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_negq ? (32'd0 - r_acc) : r_acc;
    assign o_rem  = r_negr ? (32'd0 - r_rem) : r_rem;
endmodule

### src/smb_datapath.sv
// Datapath: main memory, both stacks, pointers, operand registers, ALU and divider.
// Depends on smb_pkg and smb_divider; driven by smb_ctrl through t_dp_cmd.
module smb_datapath #(
    parameter int MEM_DEPTH    = 65536,
    parameter int DATA_DEPTH   = 1024,
    parameter int RET_DEPTH    = 1024,
    parameter int DEVICE_COUNT = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smb_pkg::t_req       i_req,
    input  smb_pkg::t_dp_cmd    i_cmd,
    output smb_pkg::t_dp_status o_status,
    output logic [31:0]         o_res_value,
    output logic [16:0]         o_ip,
    output logic [10:0]         o_depth,
    output logic [2:0]          o_dev
);
    localparam int MAW = $clog2(MEM_DEPTH);
    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int DPW = $clog2(DATA_DEPTH + 1);
    localparam int RAW = $clog2(RET_DEPTH);
    localparam int RPW = $clog2(RET_DEPTH + 1);

    logic [31:0] r_mem [MEM_DEPTH];
    logic [31:0] r_ds  [DATA_DEPTH];
    logic [31:0] r_rs  [RET_DEPTH];
    logic [31:0] r_mem_q, r_ds_q, r_rs_q;

    logic [DPW-1:0]     r_dp;
    logic [RPW-1:0]     r_rp;
    logic signed [33:0] r_ip;
    logic signed [33:0] r_cur;
    logic [15:0]        r_haddr;
    logic [31:0]        r_hval;
    logic [31:0]        r_t, r_n, r_r, r_word, r_alu, r_res;
    logic [2:0]         r_dev;

    logic [DPW-1:0]     dp_m1, dp_m2;
    logic signed [33:0] cur_p1, t_ext, r_ext;
    logic [7:0]         op;
    logic [33:0]        mem_ra34, mem_wa34;
    logic [DAW-1:0]     ds_widx, ds_ridx;
    logic [31:0]        ds_wdata, special, alu_val, shift_val, neg_cnt;
    logic               word_bad;
    logic               div_done;
    logic [31:0]        quo, rem;

    assign dp_m1  = r_dp - DPW'(1);
    assign dp_m2  = r_dp - DPW'(2);
    assign cur_p1 = r_cur + 34'sd1;
    assign t_ext  = {{2{r_t[31]}}, r_t};
    assign r_ext  = {{2{r_r[31]}}, r_r};
    assign op     = r_word[{i_cmd.slot, 3'b000} +: 8];

    smb_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_n),
        .i_divisor  (r_t),
        .o_done     (div_done),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    always_comb begin
        case (i_cmd.mem_ra)
            smb_pkg::MRA_HOST:   mem_ra34 = 34'(r_haddr);
            smb_pkg::MRA_IP:     mem_ra34 = r_ip;
            smb_pkg::MRA_CUR_P1: mem_ra34 = cur_p1;
            default:             mem_ra34 = t_ext;
        endcase
        mem_wa34 = i_cmd.mem_wa_host ? 34'(r_haddr) : t_ext;
    end

    always_comb begin
        case (i_cmd.ds_wa)
            smb_pkg::DSA_DP:  ds_widx = r_dp[DAW-1:0];
            smb_pkg::DSA_DP1: ds_widx = dp_m1[DAW-1:0];
            default:          ds_widx = dp_m2[DAW-1:0];
        endcase
        ds_ridx = (i_cmd.ds_ra == smb_pkg::DSA_DP2) ? dp_m2[DAW-1:0] : dp_m1[DAW-1:0];
    end

    // Fetch addresses -1 to -5 read machine constants instead of memory.
    always_comb begin
        case (r_t)
            32'hFFFF_FFFF: special = 32'(dp_m1);
            32'hFFFF_FFFE: special = 32'(r_rp);
            32'hFFFF_FFFD: special = 32'(MEM_DEPTH);
            32'hFFFF_FFFC: special = 32'h8000_0001;
            default:       special = 32'h7FFF_FFFE;
        endcase
    end

    // Negative counts shift left; positive counts shift right with sign fill.
    always_comb begin
        neg_cnt = 32'd0 - r_t;
        if (r_t[31]) begin
            shift_val = (|neg_cnt[31:5]) ? 32'd0 : (r_n << neg_cnt[4:0]);
        end else if (|r_t[31:5]) begin
            shift_val = {32{r_n[31]}};
        end else begin
            shift_val = 32'($signed(r_n) >>> r_t[4:0]);
        end
    end

    always_comb begin
        case (op)
            smb_pkg::OP_EQ:    alu_val = (r_n == r_t) ? '1 : '0;
            smb_pkg::OP_NE:    alu_val = (r_n != r_t) ? '1 : '0;
            smb_pkg::OP_LT:    alu_val = ($signed(r_n) < $signed(r_t)) ? '1 : '0;
            smb_pkg::OP_GT:    alu_val = ($signed(r_n) > $signed(r_t)) ? '1 : '0;
            smb_pkg::OP_ADD:   alu_val = r_n + r_t;
            smb_pkg::OP_SUB:   alu_val = r_n - r_t;
            smb_pkg::OP_MUL:   alu_val = r_n * r_t;
            smb_pkg::OP_AND:   alu_val = r_n & r_t;
            smb_pkg::OP_OR:    alu_val = r_n | r_t;
            smb_pkg::OP_XOR:   alu_val = r_n ^ r_t;
            smb_pkg::OP_SHIFT: alu_val = shift_val;
            default:           alu_val = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.ds_wd)
            smb_pkg::WD_HOST:    ds_wdata = r_hval;
            smb_pkg::WD_MEM:     ds_wdata = r_mem_q;
            smb_pkg::WD_DEVCNT:  ds_wdata = 32'(DEVICE_COUNT);
            smb_pkg::WD_R:       ds_wdata = r_r;
            smb_pkg::WD_T:       ds_wdata = r_t;
            smb_pkg::WD_N:       ds_wdata = r_n;
            smb_pkg::WD_SPECIAL: ds_wdata = special;
            smb_pkg::WD_ALU:     ds_wdata = r_alu;
            smb_pkg::WD_QUO:     ds_wdata = quo;
            default:             ds_wdata = rem;
        endcase
    end

    always_comb begin
        word_bad = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (r_mem_q[8*k +: 8] > smb_pkg::OP_LAST) word_bad = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem_q <= r_mem[mem_ra34[MAW-1:0]];
        r_ds_q  <= r_ds[ds_ridx];
        r_rs_q  <= r_rs[r_rp[RAW-1:0] - RAW'(1)];
        if (i_cmd.mem_we) begin
            r_mem[mem_wa34[MAW-1:0]] <= i_cmd.mem_wa_host ? r_hval : r_n;
        end
        if (i_cmd.ds_we) begin
            r_ds[ds_widx] <= ds_wdata;
        end
        if (i_cmd.rs_we) begin
            r_rs[r_rp[RAW-1:0]] <= i_cmd.rs_wd_cur ? r_cur[31:0] : r_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp <= '0;
            r_rp <= '0;
            r_ip <= '0;
        end else begin
            case (i_cmd.dp_op)
                smb_pkg::PTR_INC:  r_dp <= r_dp + DPW'(1);
                smb_pkg::PTR_DEC:  r_dp <= dp_m1;
                smb_pkg::PTR_DEC2: r_dp <= dp_m2;
                default:           r_dp <= r_dp;
            endcase
            case (i_cmd.rp_op)
                smb_pkg::PTR_INC: r_rp <= r_rp + RPW'(1);
                smb_pkg::PTR_DEC: r_rp <= r_rp - RPW'(1);
                default:          r_rp <= r_rp;
            endcase
            case (i_cmd.ip_op)
                smb_pkg::IP_HOST:   r_ip <= 34'(r_haddr);
                smb_pkg::IP_CUR:    r_ip <= r_cur;
                smb_pkg::IP_CUR_P1: r_ip <= cur_p1;
                default:            r_ip <= r_ip;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_haddr <= i_req.address;
            r_hval  <= i_req.value;
        end
        if (i_cmd.ld_t)    r_t    <= r_ds_q;
        if (i_cmd.ld_n)    r_n    <= r_ds_q;
        if (i_cmd.ld_r)    r_r    <= r_rs_q;
        if (i_cmd.ld_word) r_word <= r_mem_q;
        if (i_cmd.ld_alu)  r_alu  <= alu_val;
        if (i_cmd.ld_dev)  r_dev  <= r_t[2:0];
        case (i_cmd.cur_op)
            smb_pkg::CUR_IP:   r_cur <= r_ip;
            smb_pkg::CUR_INC:  r_cur <= cur_p1;
            smb_pkg::CUR_T_M1: r_cur <= t_ext - 34'sd1;
            smb_pkg::CUR_R:    r_cur <= r_ext;
            default:           r_cur <= r_cur;
        endcase
        case (i_cmd.res_op)
            smb_pkg::RES_ZERO: r_res <= '0;
            smb_pkg::RES_MEM:  r_res <= r_mem_q;
            smb_pkg::RES_DS:   r_res <= r_ds_q;
            default:           r_res <= r_res;
        endcase
    end

    always_comb begin
        o_status.op         = op;
        o_status.dp_lt1     = (r_dp == '0);
        o_status.dp_lt2     = (r_dp < DPW'(2));
        o_status.dp_full    = (r_dp >= DPW'(DATA_DEPTH));
        o_status.rp_zero    = (r_rp == '0);
        o_status.rp_full    = (r_rp >= RPW'(RET_DEPTH));
        o_status.t_zero     = (r_t == '0);
        o_status.n_zero     = (r_n == '0);
        o_status.t_mem_ok   = !r_t[31] && (r_t < 32'(MEM_DEPTH));
        o_status.t_dev_ok   = !r_t[31] && (r_t < 32'(DEVICE_COUNT));
        o_status.t_special  = r_t[31] && (r_t >= 32'hFFFF_FFFB);
        o_status.cur_p1_neg = cur_p1[33];
        o_status.cur_p1_ge  = !cur_p1[33] && (cur_p1 >= 34'(MEM_DEPTH));
        o_status.ip_neg     = r_ip[33];
        o_status.ip_ge      = !r_ip[33] && (r_ip >= 34'(MEM_DEPTH));
        o_status.host_ok    = (32'(r_haddr) < 32'(MEM_DEPTH));
        o_status.word_bad   = word_bad;
        o_status.div_done   = div_done;
    end

    assign o_res_value = r_res;
    assign o_ip        = r_ip[16:0];
    assign o_depth     = 11'(r_dp);
    assign o_dev       = r_dev;
endmodule

### src/smb_ctrl.sv
// Controller: sequences host requests and the slots of an instruction word.
// Depends on smb_pkg; drives smb_datapath through t_dp_cmd.
module smb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  smb_pkg::t_req       i_req,
    input  smb_pkg::t_dp_status i_status,
    output logic                o_busy,
    output smb_pkg::t_dp_cmd    o_cmd,
    output logic                o_valid,
    output logic                o_halted,
    output logic [2:0]          o_fault,
    output logic [1:0]          o_io_kind
);
    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_RDM, S_POPD, S_TOP, S_TOPQ, S_OUT,
        S_DEC, S_RD1, S_RD2, S_RD3, S_EXEC, S_LIT, S_FETW, S_SW2,
        S_DIVW, S_DIV1, S_DIV2, S_BIN, S_NEXT, S_ENDW
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_act, n_act;
    logic       r_halted, n_halted;
    logic [2:0] r_fault, n_fault;
    logic [2:0] r_resume, n_resume;
    logic [1:0] r_slot, n_slot;
    logic [1:0] r_io, n_io;
    logic       do_halt;
    logic [2:0] halt_code;
    smb_pkg::t_dp_cmd cmd;

    always_comb begin
        cmd       = '0;
        cmd.ds_ra = smb_pkg::DSA_DP1;
        cmd.slot  = r_slot;
        n_state   = r_state;
        n_act     = r_act;
        n_halted  = r_halted;
        n_fault   = r_fault;
        n_resume  = r_resume;
        n_slot    = r_slot;
        n_io      = r_io;
        do_halt   = 1'b0;
        halt_code = smb_pkg::FLT_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.ld_req = 1'b1;
                    n_act      = i_req.action;
                    n_io       = smb_pkg::IO_NONE;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_TOP;
                case (r_act)
                    smb_pkg::ACT_WRITE: begin
                        cmd.mem_we      = i_status.host_ok;
                        cmd.mem_wa_host = 1'b1;
                    end
                    smb_pkg::ACT_READ: begin
                        cmd.mem_ra = smb_pkg::MRA_HOST;
                        n_state    = S_RDM;
                    end
                    smb_pkg::ACT_PUSH: begin
                        if (!i_status.dp_full) begin
                            cmd.ds_we = 1'b1;
                            cmd.ds_wa = smb_pkg::DSA_DP;
                            cmd.ds_wd = smb_pkg::WD_HOST;
                            cmd.dp_op = smb_pkg::PTR_INC;
                        end
                    end
                    smb_pkg::ACT_POP: begin
                        if (i_status.dp_lt1) begin
                            cmd.res_op = smb_pkg::RES_ZERO;
                            n_state    = S_OUT;
                        end else begin
                            cmd.dp_op = smb_pkg::PTR_DEC;
                            n_state   = S_POPD;
                        end
                    end
                    smb_pkg::ACT_START: begin
                        cmd.ip_op = smb_pkg::IP_HOST;
                        n_fault   = smb_pkg::FLT_NONE;
                        n_resume  = '0;
                        n_halted  = !i_status.host_ok;
                    end
                    smb_pkg::ACT_STEP: begin
                        if (!r_halted) begin
                            cmd.cur_op = smb_pkg::CUR_IP;
                            if (r_resume != '0) begin
                                // Resume a word that paused on a device request.
                                n_slot   = r_resume[1:0];
                                n_resume = '0;
                                n_state  = (r_resume == 3'd4) ? S_ENDW : S_RD1;
                            end else if (i_status.ip_ge) begin
                                do_halt = 1'b1;
                            end else if (i_status.ip_neg) begin
                                do_halt   = 1'b1;
                                halt_code = smb_pkg::FLT_ADDR;
                            end else begin
                                cmd.mem_ra = smb_pkg::MRA_IP;
                                n_state    = S_DEC;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_RDM: begin
                cmd.res_op = i_status.host_ok ? smb_pkg::RES_MEM : smb_pkg::RES_ZERO;
                n_state    = S_OUT;
            end
            S_POPD: begin
                cmd.res_op = smb_pkg::RES_DS;
                n_state    = S_OUT;
            end
            S_TOP: n_state = S_TOPQ;
            S_TOPQ: begin
                cmd.res_op = i_status.dp_lt1 ? smb_pkg::RES_ZERO : smb_pkg::RES_DS;
                n_state    = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            S_DEC: begin
                if (i_status.word_bad) begin
                    do_halt   = 1'b1;
                    halt_code = smb_pkg::FLT_OPCODE;
                end else begin
                    cmd.ld_word = 1'b1;
                    n_slot      = 2'd0;
                    n_state     = S_RD1;
                end
            end
            S_RD1: n_state = S_RD2;
            S_RD2: begin
                cmd.ld_t  = 1'b1;
                cmd.ld_r  = 1'b1;
                cmd.ds_ra = smb_pkg::DSA_DP2;
                n_state   = S_RD3;
            end
            S_RD3: begin
                cmd.ld_n = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_NEXT;
                case (i_status.op)
                    smb_pkg::OP_NOP: ;
                    smb_pkg::OP_HALT: do_halt = 1'b1;
                    smb_pkg::OP_LIT: begin
                        if (i_status.dp_full) begin
                            do_halt = 1'b1; halt_code = smb_pkg::FLT_DATA;
                        end else if (i_status.cur_p1_ge || i_status.cur_p1_neg) begin
                            do_halt = 1'b1; halt_code = smb_pkg::FLT_ADDR;
                        end else begin
                            cmd.cur_op = smb_pkg::CUR_INC;
                            cmd.mem_ra = smb_pkg::MRA_CUR_P1;
                            n_state    = S_LIT;
                        end
                    end
                    smb_pkg::OP_DEVCNT: begin
                        if (i_status.dp_full) begin
                            do_halt = 1'b1; halt_code = smb_pkg::FLT_DATA;
                        end else begin
                            cmd.ds_we = 1'b1;
                            cmd.ds_wa = smb_pkg::DSA_DP;
                            cmd.ds_wd = smb_pkg::WD_DEVCNT;
                            cmd.dp_op = smb_pkg::PTR_INC;
                        end
                    end
                    smb_pkg::OP_FROMR: begin
                        if (i_status.rp_zero) begin
                            do_halt = 1'b1; halt_code = smb_pkg::FLT_RET;
                        end else if (i_status.dp_full) begin
                            do_halt = 1'b1; halt_code = smb_pkg::FLT_DATA;
                        end else begin
                            cmd.ds_we = 1'b1;
                            cmd.ds_wa = smb_pkg::DSA_DP;
                            cmd.ds_wd = smb_pkg::WD_R;
                            cmd.dp_op = smb_pkg::PTR_INC;
                            cmd.rp_op = smb_pkg::PTR_DEC;
                        end
                    end
                    smb_pkg::OP_RET: begin
                        // An empty return stack ends execution cleanly.
                        if (i_status.rp_zero) begin
                            do_halt = 1'b1;
                        end else begin
                            cmd.cur_op = smb_pkg::CUR_R;
                            cmd.rp_op  = smb_pkg::PTR_DEC;
                        end
                    end
                    default: begin
                        if (i_status.dp_lt1) begin
                            do_halt = 1'b1; halt_code = smb_pkg::FLT_DATA;
                        end else begin
                            case (i_status.op)
                                smb_pkg::OP_DUP: begin
                                    if (i_status.dp_full) begin
                                        do_halt = 1'b1; halt_code = smb_pkg::FLT_DATA;
                                    end else begin
                                        cmd.ds_we = 1'b1;
                                        cmd.ds_wa = smb_pkg::DSA_DP;
                                        cmd.ds_wd = smb_pkg::WD_T;
                                        cmd.dp_op = smb_pkg::PTR_INC;
                                    end
                                end
                                smb_pkg::OP_DROP: cmd.dp_op = smb_pkg::PTR_DEC;
                                smb_pkg::OP_TOR: begin
                                    if (i_status.rp_full) begin
                                        do_halt = 1'b1; halt_code = smb_pkg::FLT_RET;
                                    end else begin
                                        cmd.rs_we = 1'b1;
                                        cmd.rp_op = smb_pkg::PTR_INC;
                                        cmd.dp_op = smb_pkg::PTR_DEC;
                                    end
                                end
                                smb_pkg::OP_JUMP: begin
                                    cmd.cur_op = smb_pkg::CUR_T_M1;
                                    cmd.dp_op  = smb_pkg::PTR_DEC;
                                end
                                smb_pkg::OP_CALL: begin
                                    if (i_status.rp_full) begin
                                        do_halt = 1'b1; halt_code = smb_pkg::FLT_RET;
                                    end else begin
                                        cmd.rs_we     = 1'b1;
                                        cmd.rs_wd_cur = 1'b1;
                                        cmd.rp_op     = smb_pkg::PTR_INC;
                                        cmd.cur_op    = smb_pkg::CUR_T_M1;
                                        cmd.dp_op     = smb_pkg::PTR_DEC;
                                    end
                                end
                                smb_pkg::OP_FETCH: begin
                                    if (i_status.t_special) begin
                                        cmd.ds_we = 1'b1;
                                        cmd.ds_wa = smb_pkg::DSA_DP1;
                                        cmd.ds_wd = smb_pkg::WD_SPECIAL;
                                    end else if (!i_status.t_mem_ok) begin
                                        do_halt = 1'b1; halt_code = smb_pkg::FLT_ADDR;
                                    end else begin
                                        cmd.mem_ra = smb_pkg::MRA_T;
                                        n_state    = S_FETW;
                                    end
                                end
                                smb_pkg::OP_ZRET: begin
                                    if (i_status.t_zero) begin
                                        cmd.dp_op = smb_pkg::PTR_DEC;
                                        if (i_status.rp_zero) begin
                                            do_halt = 1'b1;
                                        end else begin
                                            cmd.cur_op = smb_pkg::CUR_R;
                                            cmd.rp_op  = smb_pkg::PTR_DEC;
                                        end
                                    end
                                end
                                smb_pkg::OP_QUERY, smb_pkg::OP_INVOKE: begin
                                    cmd.dp_op = smb_pkg::PTR_DEC;
                                    if (!i_status.t_dev_ok) begin
                                        do_halt = 1'b1; halt_code = smb_pkg::FLT_DEVICE;
                                    end else begin
                                        // Pause the word; the host serves the device.
                                        cmd.ld_dev = 1'b1;
                                        cmd.ip_op  = smb_pkg::IP_CUR;
                                        n_resume   = {1'b0, r_slot} + 3'd1;
                                        n_io       = (i_status.op == smb_pkg::OP_QUERY) ?
                                                     smb_pkg::IO_QUERY : smb_pkg::IO_INVOKE;
                                        n_state    = S_TOP;
                                    end
                                end
                                default: begin
                                    if (i_status.dp_lt2) begin
                                        do_halt = 1'b1; halt_code = smb_pkg::FLT_DATA;
                                    end else begin
                                        case (i_status.op)
                                            smb_pkg::OP_SWAP: begin
                                                cmd.ds_we = 1'b1;
                                                cmd.ds_wa = smb_pkg::DSA_DP1;
                                                cmd.ds_wd = smb_pkg::WD_N;
                                                n_state   = S_SW2;
                                            end
                                            smb_pkg::OP_CCALL: begin
                                                if (!i_status.n_zero && i_status.rp_full) begin
                                                    do_halt   = 1'b1;
                                                    halt_code = smb_pkg::FLT_RET;
                                                end else begin
                                                    cmd.dp_op = smb_pkg::PTR_DEC2;
                                                    if (!i_status.n_zero) begin
                                                        cmd.rs_we     = 1'b1;
                                                        cmd.rs_wd_cur = 1'b1;
                                                        cmd.rp_op     = smb_pkg::PTR_INC;
                                                        cmd.cur_op    = smb_pkg::CUR_T_M1;
                                                    end
                                                end
                                            end
                                            smb_pkg::OP_STORE: begin
                                                if (!i_status.t_mem_ok) begin
                                                    do_halt   = 1'b1;
                                                    halt_code = smb_pkg::FLT_ADDR;
                                                end else begin
                                                    cmd.mem_we = 1'b1;
                                                    cmd.dp_op  = smb_pkg::PTR_DEC2;
                                                end
                                            end
                                            smb_pkg::OP_DIVMOD: begin
                                                if (i_status.t_zero) begin
                                                    do_halt   = 1'b1;
                                                    halt_code = smb_pkg::FLT_DIV;
                                                end else begin
                                                    cmd.div_start = 1'b1;
                                                    n_state       = S_DIVW;
                                                end
                                            end
                                            default: begin
                                                cmd.ld_alu = 1'b1;
                                                n_state    = S_BIN;
                                            end
                                        endcase
                                    end
                                end
                            endcase
                        end
                    end
                endcase
            end
            S_LIT: begin
                cmd.ds_we = 1'b1;
                cmd.ds_wa = smb_pkg::DSA_DP;
                cmd.ds_wd = smb_pkg::WD_MEM;
                cmd.dp_op = smb_pkg::PTR_INC;
                n_state   = S_NEXT;
            end
            S_FETW: begin
                cmd.ds_we = 1'b1;
                cmd.ds_wa = smb_pkg::DSA_DP1;
                cmd.ds_wd = smb_pkg::WD_MEM;
                n_state   = S_NEXT;
            end
            S_SW2: begin
                cmd.ds_we = 1'b1;
                cmd.ds_wa = smb_pkg::DSA_DP2;
                cmd.ds_wd = smb_pkg::WD_T;
                n_state   = S_NEXT;
            end
            S_DIVW: begin
                if (i_status.div_done) n_state = S_DIV1;
            end
            S_DIV1: begin
                cmd.ds_we = 1'b1;
                cmd.ds_wa = smb_pkg::DSA_DP1;
                cmd.ds_wd = smb_pkg::WD_QUO;
                n_state   = S_DIV2;
            end
            S_DIV2: begin
                cmd.ds_we = 1'b1;
                cmd.ds_wa = smb_pkg::DSA_DP2;
                cmd.ds_wd = smb_pkg::WD_REM;
                n_state   = S_NEXT;
            end
            S_BIN: begin
                cmd.ds_we = 1'b1;
                cmd.ds_wa = smb_pkg::DSA_DP2;
                cmd.ds_wd = smb_pkg::WD_ALU;
                cmd.dp_op = smb_pkg::PTR_DEC;
                n_state   = S_NEXT;
            end
            S_NEXT: begin
                if (r_slot == 2'd3) begin
                    n_state = S_ENDW;
                end else begin
                    n_slot  = r_slot + 2'd1;
                    n_state = S_RD1;
                end
            end
            S_ENDW: begin
                if (i_status.cur_p1_ge) begin
                    do_halt = 1'b1;
                end else if (i_status.cur_p1_neg) begin
                    do_halt   = 1'b1;
                    halt_code = smb_pkg::FLT_ADDR;
                end else begin
                    cmd.ip_op = smb_pkg::IP_CUR_P1;
                    n_state   = S_TOP;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_halt) begin
            n_halted = 1'b1;
            n_resume = '0;
            if (halt_code != smb_pkg::FLT_NONE) n_fault = halt_code;
            n_state = S_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_act    <= smb_pkg::ACT_WRITE;
            r_halted <= 1'b0;
            r_fault  <= smb_pkg::FLT_NONE;
            r_resume <= '0;
            r_slot   <= '0;
            r_io     <= smb_pkg::IO_NONE;
        end else begin
            r_state  <= n_state;
            r_act    <= n_act;
            r_halted <= n_halted;
            r_fault  <= n_fault;
            r_resume <= n_resume;
            r_slot   <= n_slot;
            r_io     <= n_io;
        end
    end

    assign o_cmd     = cmd;
    assign o_busy    = (r_state != S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_halted  = r_halted;
    assign o_fault   = r_fault;
    assign o_io_kind = r_io;
endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of stack_machine_bundle_core: host requests, program runs and
// stack limits, checked against a behavioral predictor kept in this module.
// Depends on smb_pkg and on the stack_machine_bundle_core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smb_pkg::*;

    localparam int MEMD = 65536;
    localparam int DSD = 1024;
    localparam int RSD = 1024;
    localparam int NDEV = 6;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 750;

    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    localparam int RUN_ON = 0;
    localparam int RUN_END = -1;
    localparam int RUN_QUERY = -2;
    localparam int RUN_INVOKE = -3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_valid;
    t_rsp o_rsp;

    stack_machine_bundle_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_rsp(o_rsp)
    );

    always #1 i_clk = ~i_clk;

    // Predicted machine state.
    logic [31:0] mem_cells [0:MEMD-1];
    bit          mem_known [0:MEMD-1];
    logic [31:0] dstk [0:DSD-1];
    logic [31:0] rstk [0:RSD-1];
    int          dptr, rptr, rslot, dev;
    longint      ip;
    bit          hlt;
    logic [2:0]  flt;
    logic [31:0] held;
    bit          touched_unknown;

    // Copy taken before a step, so a step that would read an unwritten cell can be undone.
    logic [31:0] saved_dstk [0:DSD-1];
    logic [31:0] saved_rstk [0:RSD-1];
    int          saved_dptr, saved_rptr, saved_rslot;
    longint      saved_ip;
    bit          saved_hlt;
    logic [2:0]  saved_flt;
    logic [31:0] saved_held;
    int          undo_addr [$];
    logic [31:0] undo_val [$];
    bit          undo_known [$];

    t_rsp rsp_pending [$];
    int   known_addrs [$];
    bit   burst;
    int   errors, n_items, n_results, n_steps, n_faults, n_io, idle_cycles;
    t_rsp got_rsp;

    function automatic longint sx(logic [31:0] v);
        longint x;
        x = $signed(v);
        return x;
    endfunction

    function automatic logic [31:0] mem_rd(longint a);
        if (!mem_known[a]) touched_unknown = 1'b1;
        return mem_cells[a];
    endfunction

    function automatic void mem_wr(longint a, logic [31:0] v);
        undo_addr.push_back(int'(a));
        undo_val.push_back(mem_cells[a]);
        undo_known.push_back(mem_known[a]);
        if (!mem_known[a]) known_addrs.push_back(int'(a));
        mem_cells[a] = v;
        mem_known[a] = 1'b1;
    endfunction

    function automatic logic [31:0] dpop();
        dptr--;
        return dstk[dptr];
    endfunction

    function automatic logic [31:0] shift_cell(logic [31:0] x, longint y);
        logic signed [31:0] xs;
        xs = x;
        if (y < 0) return (-y >= 32) ? 32'd0 : x << (-y);
        if (y >= 32) return x[31] ? 32'hFFFF_FFFF : 32'd0;
        return xs >>> y;
    endfunction

    function automatic int exec_op(logic [7:0] op, inout longint cur);
        int d;
        logic [31:0] t, n, r;
        longint a, b;
        d = dptr;
        if (op == OP_NOP) return RUN_ON;
        if (op == OP_HALT) return RUN_END;
        if (op == OP_LIT) begin
            if (d >= DSD) return FLT_DATA;
            cur++;
            if (cur < 0 || cur >= MEMD) return FLT_ADDR;
            dstk[dptr] = mem_rd(cur);
            dptr++;
            return RUN_ON;
        end
        if (op == OP_DEVCNT) begin
            if (d >= DSD) return FLT_DATA;
            dstk[dptr] = NDEV;
            dptr++;
            return RUN_ON;
        end
        if (op == OP_FROMR) begin
            if (rptr == 0) return FLT_RET;
            if (d >= DSD) return FLT_DATA;
            rptr--;
            dstk[dptr] = rstk[rptr];
            dptr++;
            return RUN_ON;
        end
        if (op == OP_RET) begin
            if (rptr == 0) return RUN_END;
            rptr--;
            cur = sx(rstk[rptr]);
            return RUN_ON;
        end
        if (d < 1) return FLT_DATA;
        t = dstk[d-1];
        case (op)
            OP_DUP: begin
                if (d >= DSD) return FLT_DATA;
                dstk[dptr] = t;
                dptr++;
                return RUN_ON;
            end
            OP_DROP: begin
                void'(dpop());
                return RUN_ON;
            end
            OP_TOR: begin
                if (rptr >= RSD) return FLT_RET;
                rstk[rptr] = dpop();
                rptr++;
                return RUN_ON;
            end
            OP_JUMP: begin
                cur = sx(dpop()) - 1;
                return RUN_ON;
            end
            OP_CALL: begin
                if (rptr >= RSD) return FLT_RET;
                rstk[rptr] = cur[31:0];
                rptr++;
                cur = sx(dpop()) - 1;
                return RUN_ON;
            end
            OP_FETCH: begin
                a = sx(t);
                if (a == -1) r = 32'(d - 1);
                else if (a == -2) r = 32'(rptr);
                else if (a == -3) r = 32'(MEMD);
                else if (a == -4) r = 32'h8000_0001;
                else if (a == -5) r = 32'h7FFF_FFFE;
                else if (a < 0 || a >= MEMD) return FLT_ADDR;
                else r = mem_rd(a);
                dstk[d-1] = r;
                return RUN_ON;
            end
            OP_ZRET: begin
                if (t != 0) return RUN_ON;
                void'(dpop());
                if (rptr == 0) return RUN_END;
                rptr--;
                cur = sx(rstk[rptr]);
                return RUN_ON;
            end
            OP_QUERY, OP_INVOKE: begin
                a = sx(dpop());
                if (a < 0 || a >= NDEV) return FLT_DEVICE;
                dev = int'(a);
                return (op == OP_QUERY) ? RUN_QUERY : RUN_INVOKE;
            end
            default: ;
        endcase
        if (d < 2) return FLT_DATA;
        n = dstk[d-2];
        case (op)
            OP_SWAP: begin
                dstk[d-1] = n;
                dstk[d-2] = t;
                return RUN_ON;
            end
            OP_CCALL: begin
                b = sx(n);
                if (b != 0 && rptr >= RSD) return FLT_RET;
                dptr -= 2;
                if (b != 0) begin
                    rstk[rptr] = cur[31:0];
                    rptr++;
                    cur = sx(t) - 1;
                end
                return RUN_ON;
            end
            OP_STORE: begin
                a = sx(t);
                if (a < 0 || a >= MEMD) return FLT_ADDR;
                mem_wr(a, n);
                dptr -= 2;
                return RUN_ON;
            end
            OP_DIVMOD: begin
                a = sx(t);
                b = sx(n);
                if (a == 0) return FLT_DIV;
                dstk[d-1] = 32'(b / a);
                dstk[d-2] = 32'(b % a);
                return RUN_ON;
            end
            OP_EQ:    r = (n == t) ? 32'hFFFF_FFFF : 32'd0;
            OP_NE:    r = (n != t) ? 32'hFFFF_FFFF : 32'd0;
            OP_LT:    r = (sx(n) < sx(t)) ? 32'hFFFF_FFFF : 32'd0;
            OP_GT:    r = (sx(n) > sx(t)) ? 32'hFFFF_FFFF : 32'd0;
            OP_ADD:   r = n + t;
            OP_SUB:   r = n - t;
            OP_MUL:   r = n * t;
            OP_AND:   r = n & t;
            OP_OR:    r = n | t;
            OP_XOR:   r = n ^ t;
            OP_SHIFT: r = shift_cell(n, sx(t));
            default:  return FLT_OPCODE;
        endcase
        dstk[d-2] = r;
        dptr--;
        return RUN_ON;
    endfunction

    function automatic void halt_with(logic [2:0] code);
        if (code != FLT_NONE) flt = code;
        hlt = 1'b1;
        rslot = 0;
        ip = MEMD;
    endfunction

    function automatic logic [1:0] step_word();
        longint cur;
        logic [31:0] word;
        int slot, rc;
        cur = ip;
        if (rslot != 0) begin
            word = held;
            slot = rslot;
            rslot = 0;
        end else begin
            if (cur >= MEMD) begin
                halt_with(FLT_NONE);
                return IO_NONE;
            end
            if (cur < 0) begin
                halt_with(FLT_ADDR);
                return IO_NONE;
            end
            word = mem_rd(cur);
            for (int k = 0; k < 4; k++) begin
                if (word[8*k +: 8] > OP_LAST) begin
                    halt_with(FLT_OPCODE);
                    return IO_NONE;
                end
            end
            slot = 0;
        end
        for (; slot < 4; slot++) begin
            rc = exec_op(word[8*slot +: 8], cur);
            if (rc > 0) begin
                halt_with(3'(rc));
                return IO_NONE;
            end
            if (rc == RUN_END) begin
                halt_with(FLT_NONE);
                return IO_NONE;
            end
            if (rc == RUN_QUERY || rc == RUN_INVOKE) begin
                held = word;
                rslot = slot + 1;
                ip = cur;
                return (rc == RUN_QUERY) ? IO_QUERY : IO_INVOKE;
            end
        end
        cur++;
        if (cur >= MEMD) halt_with(FLT_NONE);
        else if (cur < 0) halt_with(FLT_ADDR);
        else ip = cur;
        return IO_NONE;
    endfunction

    function automatic t_rsp predict_rsp(t_req r);
        t_rsp e;
        logic [31:0] res;
        logic [1:0] io;
        bit explicit_res;
        res = '0;
        io = IO_NONE;
        explicit_res = 1'b0;
        dev = 0;
        case (r.action)
            ACT_WRITE: mem_wr(r.address, r.value);
            ACT_READ: begin
                explicit_res = 1'b1;
                res = mem_rd(r.address);
            end
            ACT_PUSH: begin
                if (dptr < DSD) begin
                    dstk[dptr] = r.value;
                    dptr++;
                end
            end
            ACT_POP: begin
                explicit_res = 1'b1;
                if (dptr > 0) res = dpop();
            end
            ACT_START: begin
                flt = FLT_NONE;
                rslot = 0;
                hlt = 1'b0;
                ip = r.address;
            end
            ACT_STEP: if (!hlt) io = step_word();
            default: ;
        endcase
        if (!explicit_res && dptr > 0) res = dstk[dptr-1];
        e.result_value = res;
        e.instr_address = hlt ? 17'(MEMD) : ip[16:0];
        e.halted = hlt;
        e.fault = flt;
        e.io_request = io;
        e.io_device = (io != IO_NONE) ? 3'(dev) : 3'd0;
        e.data_depth = 11'(dptr);
        return e;
    endfunction

    function automatic void save_state();
        saved_dstk = dstk;
        saved_rstk = rstk;
        saved_dptr = dptr;
        saved_rptr = rptr;
        saved_rslot = rslot;
        saved_ip = ip;
        saved_hlt = hlt;
        saved_flt = flt;
        saved_held = held;
        undo_addr.delete();
        undo_val.delete();
        undo_known.delete();
    endfunction

    function automatic void restore_state();
        dstk = saved_dstk;
        rstk = saved_rstk;
        dptr = saved_dptr;
        rptr = saved_rptr;
        rslot = saved_rslot;
        ip = saved_ip;
        hlt = saved_hlt;
        flt = saved_flt;
        held = saved_held;
        while (undo_addr.size() > 0) begin
            mem_cells[undo_addr[$]] = undo_val[$];
            mem_known[undo_addr[$]] = undo_known[$];
            void'(undo_addr.pop_back());
            void'(undo_val.pop_back());
            void'(undo_known.pop_back());
        end
    endfunction

    // Predicts one request and sends it; a request that would read a cell never written
    // is withdrawn and the prediction undone.
    task automatic issue(input logic [2:0] act, input int addr, input logic [31:0] val);
        t_req r;
        t_rsp e;
        int gap;
        r.action = act;
        r.address = addr[15:0];
        r.value = val;
        touched_unknown = 1'b0;
        save_state();
        e = predict_rsp(r);
        if (touched_unknown) begin
            restore_state();
            return;
        end
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        rsp_pending.push_back(e);
        n_items++;
        if (act == ACT_STEP) n_steps++;
        if (act == ACT_STEP && e.fault != FLT_NONE) n_faults++;
        if (e.io_request != IO_NONE) n_io++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (rsp_pending.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pack_ops(logic [7:0] a, b, c, d);
        return {d, c, b, a};
    endfunction

    task automatic run_steps(input int max_steps, input bit host_push);
        for (int i = 0; i < max_steps && !hlt; i++) begin
            if (host_push && $urandom_range(0, 4) == 0) issue(ACT_PUSH, 0, $urandom_range(0, 7));
            issue(ACT_STEP, 0, 0);
        end
    endtask

    task automatic load_cells(input int base, input logic [31:0] cells [$]);
        foreach (cells[i]) issue(ACT_WRITE, base + i, cells[i]);
    endtask

    task automatic test_host_access();
        issue(ACT_WRITE, 0, 32'h8000_0000);
        issue(ACT_WRITE, 65535, 32'h7FFF_FFFF);
        issue(ACT_READ, 0, 0);
        issue(ACT_READ, 65535, 0);
        issue(ACT_POP, 0, 0);
        issue(ACT_PUSH, 0, 32'h8000_0000);
        issue(ACT_PUSH, 0, 32'h7FFF_FFFF);
        issue(ACT_POP, 0, 0);
        issue(ACT_POP, 0, 0);
        issue(ACT_SPARE6, 16'hFFFF, 32'hFFFF_FFFF);
        issue(ACT_SPARE7, 0, 0);
        // The cell at address 0 holds an opcode byte above the last one.
        issue(ACT_STEP, 0, 0);
        issue(ACT_STEP, 0, 0);
    endtask

    task automatic test_arith_specials();
        load_cells(16, '{pack_ops(OP_LIT, OP_LIT, OP_DIVMOD, OP_DROP), 32'h8000_0000,
                         32'hFFFF_FFFF, pack_ops(OP_LIT, OP_FETCH, OP_LIT, OP_FETCH),
                         32'hFFFF_FFFF, 32'hFFFF_FFFD, pack_ops(OP_LIT, OP_FETCH, OP_LIT, OP_FETCH),
                         32'hFFFF_FFFC, 32'hFFFF_FFFB, pack_ops(OP_LIT, OP_FETCH, OP_LIT, OP_SHIFT),
                         32'hFFFF_FFFE, 32'hFFFF_FFD8, pack_ops(OP_DEVCNT, OP_QUERY, OP_LIT, OP_INVOKE),
                         32'd2, pack_ops(OP_LIT, OP_LIT, OP_DIVMOD, OP_NOP), 32'd5, 32'd0});
        issue(ACT_START, 16, 0);
        run_steps(12, 1'b0);
    endtask

    task automatic test_calls_returns();
        load_cells(40, '{pack_ops(OP_LIT, OP_CALL, OP_HALT, OP_NOP), 32'd43,
                         pack_ops(OP_RET, OP_NOP, OP_NOP, OP_NOP),
                         pack_ops(OP_LIT, OP_LIT, OP_SUB, OP_ZRET), 32'd7, 32'd7});
        issue(ACT_START, 40, 0);
        run_steps(6, 1'b0);
        // Let every response arrive before the next program starts.
        drain();
    endtask

    task automatic test_boundaries_faults();
        issue(ACT_WRITE, 65535, pack_ops(OP_NOP, OP_NOP, OP_NOP, OP_NOP));
        issue(ACT_START, 65535, 0);
        issue(ACT_STEP, 0, 0);
        issue(ACT_WRITE, 65535, pack_ops(OP_LIT, OP_NOP, OP_NOP, OP_NOP));
        issue(ACT_START, 65535, 0);
        issue(ACT_STEP, 0, 0);
        load_cells(50, '{32'h1E00_0000, pack_ops(OP_LIT, OP_INVOKE, OP_NOP, OP_NOP), 32'd9,
                         pack_ops(OP_LIT, OP_JUMP, OP_QUERY, OP_NOP), 32'd0});
        issue(ACT_START, 50, 0);
        issue(ACT_STEP, 0, 0);
        issue(ACT_START, 51, 0);
        issue(ACT_STEP, 0, 0);
        // A jump to address 0 followed by a query leaves the pointer one below zero.
        issue(ACT_PUSH, 0, 32'd1);
        issue(ACT_START, 53, 0);
        run_steps(3, 1'b0);
    endtask

    function automatic logic [31:0] pick_operand(int base, int ncells);
        case ($urandom_range(0, 3))
            0: return base + $urandom_range(0, ncells + 1);
            1: return $urandom_range(0, 8);
            2: return -$urandom_range(1, 6);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_programs();
        int goal, base, ncells, i, nlit, pick;
        logic [31:0] w;
        goal = n_items + RANDOM_ITEMS;
        while (n_items < goal) begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8) begin
                base = $urandom_range(64, 2000);
                ncells = $urandom_range(2, 8);
                i = 0;
                while (i < ncells) begin
                    nlit = 0;
                    for (int k = 0; k < 4; k++) begin
                        w[8*k +: 8] = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(30, 255))
                                                                     : 8'($urandom_range(0, 29));
                        if (w[8*k +: 8] == OP_LIT) nlit++;
                    end
                    issue(ACT_WRITE, base + i, w);
                    i++;
                    repeat (nlit) begin
                        issue(ACT_WRITE, base + i, pick_operand(base, ncells));
                        i++;
                    end
                end
                repeat ($urandom_range(0, 4)) issue(ACT_PUSH, 0, pick_operand(base, ncells));
                issue(ACT_START, base, 0);
                run_steps(16, 1'b1);
            end else begin
                repeat (6) begin
                    w = $urandom;
                    pick = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
                    case (3'($urandom_range(0, 7)))
                        ACT_READ:  issue(ACT_READ, pick, w);
                        ACT_START: issue(ACT_START, $urandom_range(0, 1) ? pick : $urandom, w);
                        ACT_WRITE: issue(ACT_WRITE, $urandom_range(0, 65535), w);
                        ACT_PUSH:  issue(ACT_PUSH, $urandom, w);
                        ACT_POP:   issue(ACT_POP, $urandom, w);
                        ACT_STEP:  issue(ACT_STEP, $urandom, w);
                        ACT_SPARE6: issue(ACT_SPARE6, $urandom, w);
                        default:   issue(ACT_SPARE7, $urandom, w);
                    endcase
                end
            end
        end
        burst = 1'b0;
    endtask

    // Self-looping words fill the return stack, then the data stack, until each overflows.
    task automatic test_stack_limits();
        load_cells(3000, '{pack_ops(OP_LIT, OP_CALL, OP_NOP, OP_NOP), 32'd3000});
        issue(ACT_START, 3000, 0);
        run_steps(RSD + 8, 1'b0);
        load_cells(3100, '{pack_ops(OP_DUP, OP_DUP, OP_LIT, OP_JUMP), 32'd3100});
        issue(ACT_PUSH, 0, 32'd1);
        issue(ACT_START, 3100, 0);
        run_steps(DSD / 2 + 8, 1'b0);
    endtask

    function automatic bit field_ok(string nm, logic [31:0] ev, logic [31:0] av);
        if (ev === av) return 1'b1;
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, nm, ev, av);
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            n_results++;
            if (rsp_pending.size() == 0) begin
                $display("%0t: unexpected response, actual %p", $realtime, o_rsp);
                errors++;
            end else begin
                got_rsp = rsp_pending.pop_front();
                if (!(field_ok("result_value", got_rsp.result_value, o_rsp.result_value)
                      & field_ok("instr_address", got_rsp.instr_address, o_rsp.instr_address)
                      & field_ok("halted", got_rsp.halted, o_rsp.halted)
                      & field_ok("fault", got_rsp.fault, o_rsp.fault)
                      & field_ok("io_request", got_rsp.io_request, o_rsp.io_request)
                      & field_ok("io_device", got_rsp.io_device, o_rsp.io_device)
                      & field_ok("data_depth", got_rsp.data_depth, o_rsp.data_depth)))
                    errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("stack_machine_bundle_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        dptr = 0;
        rptr = 0;
        rslot = 0;
        ip = 0;
        hlt = 1'b0;
        flt = FLT_NONE;
        held = '0;
        burst = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_host_access();
        test_arith_specials();
        test_calls_returns();
        test_boundaries_faults();
        test_random_programs();
        test_stack_limits();
        drain();
        repeat (300) @(posedge i_clk);
        $display("covered %0d requests (%0d steps), %0d responses checked", n_items, n_steps,
                 n_results);
        $display("steps ending in a fault: %0d, device pauses: %0d", n_faults, n_io);
        if (errors == 0 && rsp_pending.size() == 0) begin
            $display("stack_machine_bundle_core regression: pass");
        end else begin
            $display("stack_machine_bundle_core regression: fail");
        end
        $finish;
    end

endmodule
